// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks (the top level includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// File: hw/rtl/vlma_pkg.sv
// Shared types and constants of the variable-length moving average unit.
`default_nettype none

package vlma_pkg;

  localparam int LEN_W = 9;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic update;
    logic write_new;
    logic walk_rd;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic same_len;
    logic walk_last;
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/vlma_div.sv
// Radix-2 restoring signed divider, sum by window length, truncated toward zero.
`default_nettype none

module vlma_div #(
  parameter int SUM_W = 25,
  parameter int Q_W   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [SUM_W-1:0]       dividend_i,
  input  wire logic [vlma_pkg::LEN_W-1:0]    divisor_i,
  output logic                               busy_o,
  output logic [Q_W-1:0]                     quot_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int LW    = vlma_pkg::LEN_W;

  logic             busy_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] mag_q;
  logic [LW-1:0]    rem_q;

  logic [SUM_W-1:0] abs_v;
  logic [LW:0]      trial;
  logic             ge;
  logic [LW:0]      diff;
  logic [Q_W-1:0]   q_mag;

  assign abs_v = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign trial = {rem_q, mag_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(SUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= abs_v;
      rem_q <= '0;
      neg_q <= dividend_i[SUM_W-1];
    end else if (busy_q) begin
      mag_q <= {mag_q[SUM_W-2:0], ge};
      rem_q <= ge ? diff[LW-1:0] : trial[LW-1:0];
    end
  end

  assign q_mag  = mag_q[Q_W-1:0];
  assign quot_o = neg_q ? (~q_mag + 1'b1) : q_mag;
  assign busy_o = busy_q;

endmodule

`default_nettype wire

// File: hw/rtl/vlma_datapath.sv
// Datapath: sample store, running sum, window register, divider and result register.
`default_nettype none

module vlma_datapath #(
  parameter int MAX_DEPTH   = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire vlma_pkg::cmd_t                    cmd_i,
  output vlma_pkg::sts_t                         sts_o,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [vlma_pkg::LEN_W-1:0]        cfg_wdata_i,
  output logic [SAMPLE_BITS-1:0]                 average_o
);

  localparam int ADDR_W = $clog2(MAX_DEPTH);
  localparam int SUM_W  = SAMPLE_BITS + ADDR_W + 1;
  localparam int LW     = vlma_pkg::LEN_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DEPTH - 1);

  logic signed [SAMPLE_BITS-1:0] store [MAX_DEPTH];

  logic [LW-1:0]                 win_q;
  logic [LW-1:0]                 prev_q;
  logic [LW-1:0]                 len_q;
  logic [LW-1:0]                 cnt_q;
  logic [ADDR_W-1:0]             pos_q;
  logic [ADDR_W-1:0]             wp_q;
  logic                          acc_vld_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic [SAMPLE_BITS-1:0]        out_q;

  logic [LW-1:0]          cfg_len;
  logic [ADDR_W-1:0]      len_mod;
  logic [ADDR_W:0]        diff;
  logic [ADDR_W:0]        wrapped;
  logic [ADDR_W-1:0]      leave_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic signed [SAMPLE_BITS-1:0] wr_data;
  logic                   wr_en;
  logic [ADDR_W-1:0]      pos_inc;
  logic [ADDR_W-1:0]      wp_inc;
  logic [ADDR_W-1:0]      wp_dec;
  logic [SAMPLE_BITS-1:0] quot;
  logic                   div_busy;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_len = LW'(1);
    end else if (32'(cfg_wdata_i) > MAX_DEPTH) begin
      cfg_len = LW'(MAX_DEPTH);
    end else begin
      cfg_len = cfg_wdata_i;
    end
  end

  // entry leaving the window, window_length places back (mod depth)
  assign len_mod    = (32'(win_q) >= MAX_DEPTH) ? '0 : ADDR_W'(win_q);
  assign diff       = {1'b0, pos_q} - {1'b0, len_mod};
  assign wrapped    = diff + (ADDR_W+1)'(MAX_DEPTH);
  assign leave_addr = diff[ADDR_W] ? wrapped[ADDR_W-1:0] : diff[ADDR_W-1:0];

  assign pos_inc = (pos_q == LAST_ADDR) ? '0 : pos_q + 1'b1;
  assign wp_inc  = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
  assign wp_dec  = (wp_q == '0) ? LAST_ADDR : wp_q - 1'b1;

  assign rd_addr = cmd_i.capture ? leave_addr : wp_q;
  assign wr_en   = cmd_i.clear_step | cmd_i.update | cmd_i.write_new;
  assign wr_addr = cmd_i.clear_step ? wp_q : pos_q;
  assign wr_data = cmd_i.clear_step ? '0 : samp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture || cmd_i.walk_rd) begin
      rd_data_q <= store[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= LW'(1);
      prev_q    <= '0;
      pos_q     <= '0;
      wp_q      <= '0;
      cnt_q     <= '0;
      acc_vld_q <= 1'b0;
      sum_q     <= '0;
    end else begin
      acc_vld_q <= cmd_i.walk_rd;
      if (cfg_we_i) begin
        win_q <= cfg_len;
      end
      if (cmd_i.clear_step) begin
        wp_q <= wp_inc;
      end
      if (cmd_i.update) begin
        sum_q  <= sum_q + SUM_W'(samp_q) - SUM_W'(rd_data_q);
        prev_q <= len_q;
        pos_q  <= pos_inc;
      end
      if (cmd_i.write_new) begin
        sum_q  <= '0;
        wp_q   <= pos_q;
        cnt_q  <= '0;
        prev_q <= len_q;
        pos_q  <= pos_inc;
      end
      if (cmd_i.walk_rd) begin
        wp_q  <= wp_dec;
        cnt_q <= cnt_q + 1'b1;
      end
      if (acc_vld_q) begin
        sum_q <= sum_q + SUM_W'(rd_data_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      samp_q <= sample_i;
      len_q  <= win_q;
    end
    if (cmd_i.load_out) begin
      out_q <= quot;
    end
  end

  vlma_div #(
    .SUM_W (SUM_W),
    .Q_W   (SAMPLE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (len_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign sts_o.div_busy   = div_busy;
  assign sts_o.clear_last = (wp_q == LAST_ADDR);
  assign sts_o.same_len   = (win_q == prev_q);
  assign sts_o.walk_last  = (cnt_q == len_q - LW'(1));
  assign average_o        = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/vlma_ctrl.sv
// Controller: clearing pass, sum update or window walk, divide, result handoff.
`default_nettype none

module vlma_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire vlma_pkg::sts_t  sts_i,
  output vlma_pkg::cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAVE,
    ST_WRITE,
    ST_WALK,
    ST_WALK_END,
    ST_DIV_START,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.same_len ? ST_LEAVE : ST_WRITE;
        end
      end
      ST_LEAVE: begin
        cmd_o.update = 1'b1;
        state_d = ST_DIV_START;
      end
      ST_WRITE: begin
        cmd_o.write_new = 1'b1;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_rd = 1'b1;
        if (sts_i.walk_last) begin
          state_d = ST_WALK_END;
        end
      end
      ST_WALK_END: begin
        state_d = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

// File: hw/rtl/variable_length_moving_average_unit.sv
// Variable-length moving average over a circular sample store, top level.
`default_nettype none

// Each sample transaction is written into a circular store of MAX_DEPTH
// entries and answered by one transaction carrying the mean of the newest
// window_length samples, truncated toward zero. After reset the block zeroes
// the whole store, one entry per cycle, before taking samples; window_length
// writes are taken at any time. window_length 0 acts as 1 and values above
// MAX_DEPTH act as MAX_DEPTH. With the length unchanged an item takes one
// store read, one add/subtract, then a one-bit-per-cycle divider over the
// SUM_W-bit sum (SUM_W = SAMPLE_BITS + log2(MAX_DEPTH) + 1, 25 at default).
// After a length change the sum is rebuilt by reading all window_length
// entries through the store's single read port. A finished result waits in
// an output register while the next sample is accepted.

`include "assert_macros.svh"

module variable_length_moving_average_unit #(
  parameter int MAX_DEPTH   = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [vlma_pkg::LEN_W-1:0]         cfg_wdata_i,  // window_length
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // sample
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata   // average
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  vlma_pkg::cmd_t         cmd;
  vlma_pkg::sts_t         sts;
  logic [SAMPLE_BITS-1:0] average;

  vlma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vlma_datapath #(
    .MAX_DEPTH   (MAX_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .average_o   (average)
  );

  assign m_axis_tdata = TDATA_W'(average);

  `ASSERT_CLK(a_cmd_onehot0, $onehot0(cmd), "more than one datapath command at once")
  `ASSERT_NEVER(a_accept_div_busy, s_axis_tvalid && s_axis_tready && sts.div_busy,
                "sample accepted while divider busy")
  `ASSERT_CLK(a_div_start_idle, cmd.div_start |=> sts.div_busy,
              "divider did not start")

endmodule

`default_nettype wire

// File: tb/variable_length_moving_average_unit_test.sv
// Testbench for the variable-length moving average unit: directed cases and random streams checked against a predictor.
`timescale 1ns / 100ps

module variable_length_moving_average_unit_test;

  localparam int DEPTH     = 256;
  localparam int HOLD_CYC  = 400;
  localparam int RAND_GOAL = 2000;

  typedef enum int {MIXED, PIN_LOW, PIN_HIGH} sample_mode_e;

  class average_scoreboard;
    logic signed [15:0] sample_mem [DEPTH];
    int                 wr_pos;
    longint             window_sum;
    int                 prev_len;
    int                 win_len;
    logic [15:0]        expected_averages [$];
    int                 errors;
    int                 checked;

    function new();
      foreach (sample_mem[i]) sample_mem[i] = '0;
      wr_pos     = 0;
      window_sum = 0;
      prev_len   = 0;
      win_len    = 1;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_length(logic [vlma_pkg::LEN_W-1:0] raw);
      int v;
      v = int'(raw);
      if (v == 0) v = 1;
      if (v > DEPTH) v = DEPTH;
      win_len = v;
    endfunction

    // Running sum while the length holds, full window walk after a change.
    function void predict_average(logic signed [15:0] s);
      logic signed [15:0] leaving;
      longint             mean;
      int                 pos;
      pos     = wr_pos;
      leaving = sample_mem[(pos + DEPTH - (win_len % DEPTH)) % DEPTH];
      sample_mem[pos] = s;
      if (win_len == prev_len) begin
        window_sum = window_sum + longint'(s) - longint'(leaving);
      end else begin
        window_sum = 0;
        for (int i = 0; i < win_len; i++)
          window_sum += longint'(sample_mem[(pos + DEPTH - i) % DEPTH]);
      end
      prev_len = win_len;
      mean     = window_sum / longint'(win_len);
      wr_pos   = (pos + 1) % DEPTH;
      expected_averages.push_back(mean[15:0]);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_average(logic [15:0] got);
      logic [15:0] want;
      checked++;
      if (expected_averages.size() == 0) begin
        report($sformatf("average %0d with no sample pending", $signed(got)));
        return;
      end
      want = expected_averages.pop_front();
      if (got !== want)
        report($sformatf("average #%0d: got %0d, want %0d", checked, $signed(got),
                         $signed(want)));
    endtask
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [vlma_pkg::LEN_W-1:0]  cfg_wdata_i;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [15:0]                 s_axis_tdata;  // sample
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [15:0]                 m_axis_tdata;  // average

  average_scoreboard  sb = new();
  logic signed [15:0] batch [$];
  bit                 steady;
  bit                 hold_req;
  int                 hold_left;
  int                 samples_sent;
  int                 settings_used;
  int                 min_len = DEPTH;
  int                 max_len = 0;

  variable_length_moving_average_unit #(
    .MAX_DEPTH  (DEPTH),
    .SAMPLE_BITS(16)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic write_length(input logic [vlma_pkg::LEN_W-1:0] raw);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= raw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_length(raw);
    settings_used++;
    if (sb.win_len < min_len) min_len = sb.win_len;
    if (sb.win_len > max_len) max_len = sb.win_len;
  endtask

  task automatic send_sample(input logic signed [15:0] s);
    while (!steady && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_average(s);
    samples_sent++;
  endtask

  task automatic play_batch();
    foreach (batch[i]) send_sample(batch[i]);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_averages.size() != 0) @(posedge clk_i);
    batch.delete();
  endtask

  function automatic logic signed [15:0] pick_sample(sample_mode_e mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      PIN_LOW:  return 16'sh8000;
      PIN_HIGH: return 16'sh7fff;
      default: begin
        if (r < 70) return 16'($urandom);
        if (r < 85) begin
          case ($urandom_range(3))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return -16'sd1;
            default: return 16'sd0;
          endcase
        end
        return $signed(16'($urandom_range(200))) - 16'sd100;
      end
    endcase
  endfunction

  function automatic logic [vlma_pkg::LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 9'($urandom_range(8, 1));
    if (r < 70) return 9'($urandom_range(32, 1));
    if (r < 85) return 9'($urandom_range(511));
    case ($urandom_range(5))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd255;
      3:       return 9'd256;
      4:       return 9'd257;
      default: return 9'd511;
    endcase
  endfunction

  // receiver: random backpressure plus one long hold-off
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_average(m_axis_tdata);
      if (hold_req) begin
        hold_left = HOLD_CYC;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 27);
      end
    end
  end

  initial begin
    int                         phase;
    int                         count;
    int                         random_items;
    logic [vlma_pkg::LEN_W-1:0] len_raw;
    sample_mode_e               mode;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset length of one, extremes
    batch = '{16'sd0, 16'sh7fff, 16'sh8000, -16'sd1};
    play_batch();
    // oversized length, window reaches past the first samples
    write_length(9'd300);
    batch = '{16'sd100, -16'sd7};
    play_batch();
    // zero length acts as one
    write_length(9'd0);
    batch = '{16'sd5, -16'sd5};
    play_batch();
    // truncation toward zero on negative sums
    write_length(9'd2);
    batch = '{-16'sd1, 16'sd0, -16'sd3, 16'sd3};
    play_batch();
    write_length(9'd511);
    batch = '{16'sh7fff};
    play_batch();
    // saturates to the same length, no rebuild
    write_length(9'd257);
    batch = '{-16'sd2, 16'sd9};
    play_batch();
    write_length(9'd256);
    batch = '{16'sh8000};
    play_batch();
    write_length(9'd3);
    batch = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000};
    play_batch();

    phase        = 0;
    random_items = 0;
    while (random_items < RAND_GOAL) begin
      phase++;
      steady  = (phase >= 4 && phase < 10);
      len_raw = pick_length();
      count   = $urandom_range(60, 10);
      mode    = MIXED;
      if (phase <= 2) begin
        // fill the full store with one extreme each
        len_raw = 9'd256;
        count   = DEPTH + 4;
        mode    = (phase == 1) ? PIN_LOW : PIN_HIGH;
      end else if ($urandom_range(99) < 10) begin
        mode = ($urandom_range(1) != 0) ? PIN_LOW : PIN_HIGH;
      end
      if (phase == 5) count = 60;
      write_length(len_raw);
      repeat (count) batch.push_back(pick_sample(mode));
      if (phase == 5) hold_req = 1'b1;
      play_batch();
      random_items += count;
    end

    steady = 1'b0;
    repeat (64) @(posedge clk_i);

    $display("covered %0d samples over %0d window settings, effective lengths %0d to %0d",
             samples_sent, settings_used, min_len, max_len);
    $display("%0d averages checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("variable_length_moving_average_unit_test OK");
    end else begin
      $display("variable_length_moving_average_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("variable_length_moving_average_unit_test NOT OK");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/vlma_pkg.sv
hw/rtl/vlma_div.sv
hw/rtl/vlma_datapath.sv
hw/rtl/vlma_ctrl.sv
hw/rtl/variable_length_moving_average_unit.sv
tb/variable_length_moving_average_unit_test.sv
